FILE: hw/rtl/escstrip_pkg.sv
package escstrip_pkg;

   // Line buffer geometry
   localparam int LINE_CAPACITY = 64;
   localparam int LINE_ADDR_W   = $clog2(LINE_CAPACITY);
   localparam int LINE_LEN_W    = $clog2(LINE_CAPACITY + 1);

   // Byte codes seen on the terminal stream
   localparam logic [7:0] ChrBel       = 8'h07;
   localparam logic [7:0] ChrBs        = 8'h08;
   localparam logic [7:0] ChrTab       = 8'h09;
   localparam logic [7:0] ChrLf        = 8'h0A;
   localparam logic [7:0] ChrCr        = 8'h0D;
   localparam logic [7:0] ChrEsc       = 8'h1B;
   localparam logic [7:0] ChrSpace     = 8'h20;
   localparam logic [7:0] ChrAt        = 8'h40;
   localparam logic [7:0] ChrLBracket  = 8'h5B;
   localparam logic [7:0] ChrBackslash = 8'h5C;
   localparam logic [7:0] ChrRBracket  = 8'h5D;
   localparam logic [7:0] ChrTilde     = 8'h7E;
   localparam logic [7:0] ChrDel       = 8'h7F;

   // Escape parser phase
   typedef enum logic [3:0] {
      PHASE_TEXT = 4'b0001,
      PHASE_ESC  = 4'b0010,
      PHASE_CSI  = 4'b0100,
      PHASE_OSC  = 4'b1000
   } phase_type;

   // Line buffer sequencer
   typedef enum logic [3:0] {
      CTL_IDLE = 4'b0001,
      CTL_TAB2 = 4'b0010,
      CTL_READ = 4'b0100,
      CTL_SEND = 4'b1000
   } ctl_type;

endpackage

FILE: hw/rtl/terminal_escape_strip_line_assembler.sv
// Strips ANSI escape sequences (ESC plus one byte, CSI up to a final byte
// '@'..'~', OSC up to BEL or ESC '\') from a terminal byte stream and builds
// the printable text into a 64-character line buffer held in a synchronous
// RAM. CR clears the line, BS/DEL drop the last character, TAB adds two
// spaces, other control bytes are discarded, and LF sends the line out one
// character per rsp transfer, flagging the last character, an empty line
// (a single zero character) and truncation. TAB passes through an extra
// CTL_TAB2 state, since each space is one RAM write. On LF the line is
// read back one character at a time (a RAM read in CTL_READ, then the load
// of the output register in CTL_SEND), and req_ready stays low until the
// last character is loaded, also through any rsp_ready stall; an empty line
// goes straight to CTL_SEND. The RAM needs no clearing after reset: only
// entries below the line length are ever read.
module terminal_escape_strip_line_assembler (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_line_char,
   output logic       rsp_line_last,
   output logic       rsp_line_empty,
   output logic       rsp_line_truncated
);

   localparam int AW = escstrip_pkg::LINE_ADDR_W;
   localparam int LW = escstrip_pkg::LINE_LEN_W;

   // Line RAM
   logic [7:0] line_mem [escstrip_pkg::LINE_CAPACITY];
   logic [7:0] rd_data_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;

   // Control and line state
   escstrip_pkg::phase_type phase_ff, phase_in;
   escstrip_pkg::ctl_type   ctl_ff, ctl_in;
   logic          osc_esc_ff, osc_esc_in;
   logic [LW-1:0] line_len_ff, line_len_in;
   logic          ovf_ff, ovf_in;

   // Emission state
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [LW-1:0] emit_len_ff, emit_len_in;
   logic          emit_trunc_ff, emit_trunc_in;
   logic          emit_empty_ff, emit_empty_in;

   // Output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff, rsp_char_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_empty_ff, rsp_empty_in;
   logic       rsp_trunc_ff, rsp_trunc_in;

   logic req_xfer;
   logic out_free;
   logic send_last;
   logic has_room;

   assign req_ready = (ctl_ff == escstrip_pkg::CTL_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign has_room  = (line_len_ff < LW'(escstrip_pkg::LINE_CAPACITY));
   assign send_last = emit_empty_ff || ((LW'(rd_idx_ff) + LW'(1)) == emit_len_ff);

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_char      = rsp_char_ff;
   assign rsp_line_last      = rsp_last_ff;
   assign rsp_line_empty     = rsp_empty_ff;
   assign rsp_line_truncated = rsp_trunc_ff;

   // RAM write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= line_mem[rd_idx_ff];
   end

   // Next-state logic
   always_comb begin
      phase_in      = phase_ff;
      ctl_in        = ctl_ff;
      osc_esc_in    = osc_esc_ff;
      line_len_in   = line_len_ff;
      ovf_in        = ovf_ff;
      rd_idx_in     = rd_idx_ff;
      emit_len_in   = emit_len_ff;
      emit_trunc_in = emit_trunc_ff;
      emit_empty_in = emit_empty_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_trunc_in  = rsp_trunc_ff;
      wr_en         = 1'b0;
      wr_addr       = line_len_ff[AW-1:0];
      wr_data       = req_data_byte;

      case (ctl_ff)
         escstrip_pkg::CTL_IDLE: begin
            if (req_xfer) begin
               case (phase_ff)
                  escstrip_pkg::PHASE_ESC: begin
                     if (req_data_byte == escstrip_pkg::ChrLBracket) begin
                        phase_in = escstrip_pkg::PHASE_CSI;
                     end else if (req_data_byte == escstrip_pkg::ChrRBracket) begin
                        phase_in   = escstrip_pkg::PHASE_OSC;
                        osc_esc_in = 1'b0;
                     end else begin
                        phase_in = escstrip_pkg::PHASE_TEXT;
                     end
                  end
                  escstrip_pkg::PHASE_CSI: begin
                     if (req_data_byte inside
                         {[escstrip_pkg::ChrAt:escstrip_pkg::ChrTilde]}) begin
                        phase_in = escstrip_pkg::PHASE_TEXT;
                     end
                  end
                  escstrip_pkg::PHASE_OSC: begin
                     // BEL or ESC '\' terminates the string
                     if ((req_data_byte == escstrip_pkg::ChrBel) ||
                         (osc_esc_ff && (req_data_byte == escstrip_pkg::ChrBackslash))) begin
                        phase_in   = escstrip_pkg::PHASE_TEXT;
                        osc_esc_in = 1'b0;
                     end else begin
                        osc_esc_in = (req_data_byte == escstrip_pkg::ChrEsc);
                     end
                  end
                  default: begin
                     // plain text
                     if (req_data_byte == escstrip_pkg::ChrEsc) begin
                        phase_in = escstrip_pkg::PHASE_ESC;
                     end else if (req_data_byte == escstrip_pkg::ChrCr) begin
                        line_len_in = '0;
                        ovf_in      = 1'b0;
                     end else if (req_data_byte == escstrip_pkg::ChrLf) begin
                        emit_len_in   = line_len_ff;
                        emit_trunc_in = ovf_ff;
                        emit_empty_in = (line_len_ff == '0);
                        rd_idx_in     = '0;
                        line_len_in   = '0;
                        ovf_in        = 1'b0;
                        ctl_in        = (line_len_ff == '0) ? escstrip_pkg::CTL_SEND
                                                            : escstrip_pkg::CTL_READ;
                     end else if (req_data_byte inside
                                  {escstrip_pkg::ChrBs, escstrip_pkg::ChrDel}) begin
                        if (line_len_ff != '0) begin
                           line_len_in = line_len_ff - LW'(1);
                        end
                     end else if (req_data_byte == escstrip_pkg::ChrTab) begin
                        wr_data = escstrip_pkg::ChrSpace;
                        ctl_in  = escstrip_pkg::CTL_TAB2;
                        if (has_room) begin
                           wr_en       = 1'b1;
                           line_len_in = line_len_ff + LW'(1);
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end else if (req_data_byte < escstrip_pkg::ChrSpace) begin
                        // other control bytes are dropped
                     end else if (has_room) begin
                        wr_en       = 1'b1;
                        line_len_in = line_len_ff + LW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
               endcase
            end
         end
         escstrip_pkg::CTL_TAB2: begin
            // second space of a tab
            wr_data = escstrip_pkg::ChrSpace;
            ctl_in  = escstrip_pkg::CTL_IDLE;
            if (has_room) begin
               wr_en       = 1'b1;
               line_len_in = line_len_ff + LW'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
         escstrip_pkg::CTL_READ: begin
            // RAM read at rd_idx_ff lands in rd_data_ff next cycle
            ctl_in = escstrip_pkg::CTL_SEND;
         end
         escstrip_pkg::CTL_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = emit_empty_ff ? 8'h00 : rd_data_ff;
               rsp_last_in  = send_last;
               rsp_empty_in = emit_empty_ff;
               rsp_trunc_in = emit_trunc_ff;
               if (send_last) begin
                  ctl_in = escstrip_pkg::CTL_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + AW'(1);
                  ctl_in    = escstrip_pkg::CTL_READ;
               end
            end
         end
         default: begin
            ctl_in = escstrip_pkg::CTL_IDLE;
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= escstrip_pkg::PHASE_TEXT;
         ctl_ff       <= escstrip_pkg::CTL_IDLE;
         osc_esc_ff   <= 1'b0;
         line_len_ff  <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         ctl_ff       <= ctl_in;
         osc_esc_ff   <= osc_esc_in;
         line_len_ff  <= line_len_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      emit_len_ff   <= emit_len_in;
      emit_trunc_ff <= emit_trunc_in;
      emit_empty_ff <= emit_empty_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_trunc_ff  <= rsp_trunc_in;
   end

   // Checks
   a_len_in_range: assert property (@(posedge clock) disable iff (reset)
      line_len_ff <= LW'(escstrip_pkg::LINE_CAPACITY))
      else $error("line length beyond capacity");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_line_empty) |-> (rsp_line_last && (rsp_line_char == 8'h00)))
      else $error("empty-line result not marked last or nonzero");

   a_lf_clears: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (phase_ff == escstrip_pkg::PHASE_TEXT) &&
       (req_data_byte == escstrip_pkg::ChrLf)) |=> ((line_len_ff == '0) && !ovf_ff))
      else $error("line not cleared after LF");

   a_no_write_in_emit: assert property (@(posedge clock) disable iff (reset)
      ((ctl_ff == escstrip_pkg::CTL_READ) || (ctl_ff == escstrip_pkg::CTL_SEND)) |-> !wr_en)
      else $error("line RAM written during emission");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int RUN_LIMIT    = 1_000_000;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES  = 400;
   localparam int AW           = escstrip_pkg::LINE_ADDR_W;
   localparam int LW           = escstrip_pkg::LINE_LEN_W;

   // One emitted line character as seen on the rsp channel
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       empty;
      logic       trunc;
   } line_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_line_char;
   logic       rsp_line_last;
   logic       rsp_line_empty;
   logic       rsp_line_truncated;

   // Traffic shaping knobs
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   logic rsp_hold = 1'b0;

   int fail_count = 0;
   int bytes_sent = 0;
   int cycle_count = 0;

   // Shadow copy of the parser and line buffer
   escstrip_pkg::phase_type esc_state = escstrip_pkg::PHASE_TEXT;
   logic                    osc_esc_pending = 1'b0;
   logic [7:0]              text_buf [escstrip_pkg::LINE_CAPACITY];
   logic [LW-1:0]           text_len = '0;
   logic                    text_dropped = 1'b0;
   line_char_type           line_expect [$];

   terminal_escape_strip_line_assembler u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_line_char      (rsp_line_char),
      .rsp_line_last      (rsp_line_last),
      .rsp_line_empty     (rsp_line_empty),
      .rsp_line_truncated (rsp_line_truncated)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: random stalls, forced low during a hold-off
   always @(negedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   function automatic void append_char(input logic [7:0] c);
      if (text_len < LW'(escstrip_pkg::LINE_CAPACITY)) begin
         text_buf[text_len[AW-1:0]] = c;
         text_len = text_len + LW'(1);
      end else begin
         text_dropped = 1'b1;
      end
   endfunction

   // Advance the shadow state by one byte; LF queues the line characters
   function automatic void absorb_byte(input logic [7:0] b);
      line_char_type c;
      int i;
      case (esc_state)
         escstrip_pkg::PHASE_ESC: begin
            if (b == escstrip_pkg::ChrLBracket) begin
               esc_state = escstrip_pkg::PHASE_CSI;
            end else if (b == escstrip_pkg::ChrRBracket) begin
               esc_state = escstrip_pkg::PHASE_OSC;
               osc_esc_pending = 1'b0;
            end else begin
               esc_state = escstrip_pkg::PHASE_TEXT;
            end
         end
         escstrip_pkg::PHASE_CSI: begin
            if (b >= escstrip_pkg::ChrAt && b <= escstrip_pkg::ChrTilde) begin
               esc_state = escstrip_pkg::PHASE_TEXT;
            end
         end
         escstrip_pkg::PHASE_OSC: begin
            if (b == escstrip_pkg::ChrBel ||
                (osc_esc_pending && b == escstrip_pkg::ChrBackslash)) begin
               esc_state = escstrip_pkg::PHASE_TEXT;
               osc_esc_pending = 1'b0;
            end else begin
               osc_esc_pending = (b == escstrip_pkg::ChrEsc);
            end
         end
         default: begin
            if (b == escstrip_pkg::ChrEsc) begin
               esc_state = escstrip_pkg::PHASE_ESC;
            end else if (b == escstrip_pkg::ChrCr) begin
               text_len = '0;
               text_dropped = 1'b0;
            end else if (b == escstrip_pkg::ChrLf) begin
               if (text_len == '0) begin
                  c.ch    = 8'h00;
                  c.last  = 1'b1;
                  c.empty = 1'b1;
                  c.trunc = text_dropped;
                  line_expect.insert(line_expect.size(), c);
               end else begin
                  for (i = 0; i < int'(text_len); i++) begin
                     c.ch    = text_buf[AW'(i)];
                     c.last  = (LW'(i + 1) == text_len);
                     c.empty = 1'b0;
                     c.trunc = text_dropped;
                     line_expect.insert(line_expect.size(), c);
                  end
               end
               text_len = '0;
               text_dropped = 1'b0;
            end else if (b == escstrip_pkg::ChrBs || b == escstrip_pkg::ChrDel) begin
               if (text_len != '0) text_len = text_len - LW'(1);
            end else if (b == escstrip_pkg::ChrTab) begin
               append_char(escstrip_pkg::ChrSpace);
               append_char(escstrip_pkg::ChrSpace);
            end else if (b >= escstrip_pkg::ChrSpace) begin
               append_char(b);
            end
         end
      endcase
   endfunction

   // Check every rsp transfer against the oldest queued character
   always @(posedge clock) begin
      line_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (line_expect.size() == 0) begin
            $error("unexpected line character transfer: line_char %h", rsp_line_char);
            fail_count++;
         end else begin
            want = line_expect[0];
            line_expect.delete(0);
            if (rsp_line_char !== want.ch) begin
               $error("line_char: expected %h, got %h", want.ch, rsp_line_char);
               fail_count++;
            end
            if (rsp_line_last !== want.last) begin
               $error("line_last: expected %b, got %b", want.last, rsp_line_last);
               fail_count++;
            end
            if (rsp_line_empty !== want.empty) begin
               $error("line_empty: expected %b, got %b", want.empty, rsp_line_empty);
               fail_count++;
            end
            if (rsp_line_truncated !== want.trunc) begin
               $error("line_truncated: expected %b, got %b", want.trunc,
                      rsp_line_truncated);
               fail_count++;
            end
         end
      end
   end

   // Offer one byte, with optional idle cycles first, and wait for its transfer
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      absorb_byte(b);
      bytes_sent++;
   endtask

   function automatic logic [7:0] rand_printable();
      logic [7:0] b;
      b = 8'($urandom_range(32, 255));
      if (b == escstrip_pkg::ChrDel) b = escstrip_pkg::ChrTilde;
      return b;
   endfunction

   // One line of mixed text, edits and escape sequences, closed by LF
   task automatic send_text_line();
      int goal;
      int width;
      int n;
      logic [7:0] b;
      goal  = ($urandom_range(0, 9) == 0) ? $urandom_range(58, 72) : $urandom_range(0, 12);
      width = 0;
      while (width < goal) begin
         case ($urandom_range(0, 19))
            13: begin
               send_byte(escstrip_pkg::ChrTab);
               width += 2;
            end
            14: begin
               send_byte($urandom_range(0, 1) ? escstrip_pkg::ChrBs : escstrip_pkg::ChrDel);
               if (width > 0) width--;
            end
            15: begin
               send_byte(escstrip_pkg::ChrCr);
               width = 0;
            end
            16: begin
               // control byte with no meaning here
               do b = 8'($urandom_range(0, 31));
               while (b == escstrip_pkg::ChrBs || b == escstrip_pkg::ChrTab ||
                      b == escstrip_pkg::ChrLf || b == escstrip_pkg::ChrCr ||
                      b == escstrip_pkg::ChrEsc);
               send_byte(b);
            end
            17: begin
               // two-byte escape; a second ESC ends it as well
               b = 8'($urandom_range(0, 255));
               if (b == escstrip_pkg::ChrLBracket || b == escstrip_pkg::ChrRBracket) begin
                  b = escstrip_pkg::ChrEsc;
               end
               send_byte(escstrip_pkg::ChrEsc);
               send_byte(b);
            end
            18: begin
               send_byte(escstrip_pkg::ChrEsc);
               send_byte(escstrip_pkg::ChrLBracket);
               n = $urandom_range(0, 4);
               repeat (n) send_byte(8'($urandom_range(8'h20, 8'h3F)));
               send_byte(8'($urandom_range(escstrip_pkg::ChrAt, escstrip_pkg::ChrTilde)));
            end
            19: begin
               send_byte(escstrip_pkg::ChrEsc);
               send_byte(escstrip_pkg::ChrRBracket);
               n = $urandom_range(0, 5);
               repeat (n) begin
                  if ($urandom_range(0, 5) == 0) begin
                     send_byte(escstrip_pkg::ChrEsc);
                     send_byte(escstrip_pkg::ChrSpace);
                  end else begin
                     send_byte(rand_printable());
                  end
               end
               if ($urandom_range(0, 1)) begin
                  send_byte(escstrip_pkg::ChrBel);
               end else begin
                  send_byte(escstrip_pkg::ChrEsc);
                  send_byte(escstrip_pkg::ChrBackslash);
               end
            end
            default: begin
               send_byte(rand_printable());
               width++;
            end
         endcase
      end
      send_byte(escstrip_pkg::ChrLf);
   endtask

   // Fixed corner cases: empty line, edits, high bytes, each escape form
   task automatic test_directed();
      logic [7:0] seq [26];
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      seq = '{escstrip_pkg::ChrLf, escstrip_pkg::ChrBs, escstrip_pkg::ChrEsc,
              escstrip_pkg::ChrEsc, 8'h51, escstrip_pkg::ChrCr, 8'h80, 8'hFF,
              escstrip_pkg::ChrTab, escstrip_pkg::ChrDel,
              escstrip_pkg::ChrEsc, escstrip_pkg::ChrLBracket, 8'h3F, escstrip_pkg::ChrAt,
              escstrip_pkg::ChrEsc, escstrip_pkg::ChrLBracket, escstrip_pkg::ChrTilde,
              escstrip_pkg::ChrEsc, escstrip_pkg::ChrRBracket, escstrip_pkg::ChrEsc,
              escstrip_pkg::ChrBackslash, escstrip_pkg::ChrEsc, escstrip_pkg::ChrRBracket,
              escstrip_pkg::ChrBel, escstrip_pkg::ChrTilde, escstrip_pkg::ChrLf};
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   // Long receiver hold-off while an overfull line is built and sent
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      fork
         begin
            rsp_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      repeat (escstrip_pkg::LINE_CAPACITY + 6) send_byte(rand_printable());
      // delete after truncation, then a tab that only half fits
      send_byte(escstrip_pkg::ChrBs);
      send_byte(escstrip_pkg::ChrTab);
      send_byte(escstrip_pkg::ChrLf);
      send_byte(8'h52);
      send_byte(escstrip_pkg::ChrLf);
      send_byte(escstrip_pkg::ChrLf);
   endtask

   // Mostly well-formed lines, some raw noise bursts
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int n_bytes);
      int stop_at;
      stop_at = bytes_sent + n_bytes;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            send_text_line();
         end
      end
   endtask

   initial begin
      foreach (text_buf[i]) text_buf[i] = 8'h00;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_output_backpressure();
      test_random_traffic(0, 0, 24);
      test_random_traffic(57, 0, 24);
      test_random_traffic(0, 57, 24);
      test_random_traffic(38, 38, 24);

      @(negedge clock);
      req_valid <= 1'b0;
      while (line_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
